>>> rtl/cpg_pkg.sv
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants of the circle point generator.
// ----------------------------------------------------------------------------
package cpg_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int RADIUS_BITS_DEF = 10;

	// one point per cycle unless stalled; index of a point inside one step
	localparam int PIDX_BITS = 3;

	typedef enum logic {
		KIND_START   = 1'b0,
		KIND_ADVANCE = 1'b1
	} kind_t;

	typedef enum logic {
		ARC_FULL  = 1'b0,
		ARC_LOWER = 1'b1
	} arc_mode_t;

	// point slots in output order of a full step; the lower arc uses
	// PT_XP_YN and PT_XN_YN only
	typedef enum logic [PIDX_BITS-1:0] {
		PT_XP_YP = 3'd0,
		PT_XN_YP = 3'd1,
		PT_XP_YN = 3'd2,
		PT_XN_YN = 3'd3,
		PT_YP_XP = 3'd4,
		PT_YN_XN = 3'd5,
		PT_YP_XN = 3'd6,
		PT_YN_XP = 3'd7
	} pt_slot_t;

	typedef struct packed {
		arc_mode_t mode;
		logic      done;
	} step_ctl_t;

endpackage

>>> rtl/cpg_if.sv
// ----------------------------------------------------------------------------
// cpg_if
// Valid/ready channels of the circle point generator.
// ----------------------------------------------------------------------------
interface cpg_in_if #(
	parameter int COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [COORD_BITS-1:0]  center_x;
	logic signed [COORD_BITS-1:0]  center_y;
	logic        [RADIUS_BITS-1:0] radius;

	modport source (output valid, kind, center_x, center_y, radius, input ready);
	modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

interface cpg_out_if #(
	parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) ();
	logic                       valid;
	logic                       ready;
	logic signed [COORD_BITS:0] point_x;
	logic signed [COORD_BITS:0] point_y;
	logic                       last_of_step;
	logic                       circle_done;

	modport source (output valid, point_x, point_y, last_of_step, circle_done, input ready);
	modport sink   (input valid, point_x, point_y, last_of_step, circle_done, output ready);
endinterface

interface cpg_cfg_if ();
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> rtl/cpg_point_emitter.sv
// ----------------------------------------------------------------------------
// cpg_point_emitter
// Holds one column step and sends its symmetric points, one per cycle
// unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module cpg_point_emitter #(
	parameter int COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_valid,
	output logic                          step_ready,
	input  logic signed [COORD_BITS-1:0]  step_cx,
	input  logic signed [COORD_BITS-1:0]  step_cy,
	input  logic        [RADIUS_BITS:0]   step_x,
	input  logic        [RADIUS_BITS-1:0] step_y,
	input  cpg_pkg::step_ctl_t            step_ctl,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS:0]    point_x,
	output logic signed [COORD_BITS:0]    point_y,
	output logic                          last_of_step,
	output logic                          circle_done
);
	import cpg_pkg::*;

	localparam int PW = COORD_BITS + 1;

	// step buffer
	logic                 buf_vld_q;
	logic [PIDX_BITS-1:0] idx_q;
	logic [PW-1:0]        cx_s1;
	logic [PW-1:0]        cy_s1;
	logic [PW-1:0]        x_s1;
	logic [PW-1:0]        y_s1;
	step_ctl_t            ctl_s1;

	// output stage
	logic                 out_vld_q;
	logic [PW-1:0]        px_s2;
	logic [PW-1:0]        py_s2;
	logic                 last_s2;
	logic                 done_s2;

	logic                 out_load;
	logic                 buf_last;
	pt_slot_t             sel;
	logic [PW-1:0]        mag_x;
	logic [PW-1:0]        mag_y;
	logic                 neg_x;
	logic                 neg_y;
	logic [PW-1:0]        px_nxt;
	logic [PW-1:0]        py_nxt;

	assign out_load   = buf_vld_q && (!out_vld_q || out_ready);
	assign buf_last   = (ctl_s1.mode == ARC_LOWER) ? (idx_q == PIDX_BITS'(1))
	                                               : (idx_q == PIDX_BITS'(7));
	assign step_ready = !buf_vld_q || (out_load && buf_last);

	// lower arc starts at the third slot of the full order
	assign sel = pt_slot_t'((ctl_s1.mode == ARC_LOWER) ? idx_q + PIDX_BITS'(PT_XP_YN)
	                                                   : idx_q);

	always_comb begin
		mag_x = x_s1;
		mag_y = y_s1;
		neg_x = 1'b0;
		neg_y = 1'b0;
		unique case (sel)
			PT_XP_YP: begin
				mag_x = x_s1; neg_x = 1'b0; mag_y = y_s1; neg_y = 1'b0;
			end
			PT_XN_YP: begin
				mag_x = x_s1; neg_x = 1'b1; mag_y = y_s1; neg_y = 1'b0;
			end
			PT_XP_YN: begin
				mag_x = x_s1; neg_x = 1'b0; mag_y = y_s1; neg_y = 1'b1;
			end
			PT_XN_YN: begin
				mag_x = x_s1; neg_x = 1'b1; mag_y = y_s1; neg_y = 1'b1;
			end
			PT_YP_XP: begin
				mag_x = y_s1; neg_x = 1'b0; mag_y = x_s1; neg_y = 1'b0;
			end
			PT_YN_XN: begin
				mag_x = y_s1; neg_x = 1'b1; mag_y = x_s1; neg_y = 1'b1;
			end
			PT_YP_XN: begin
				mag_x = y_s1; neg_x = 1'b0; mag_y = x_s1; neg_y = 1'b1;
			end
			PT_YN_XP: begin
				mag_x = y_s1; neg_x = 1'b1; mag_y = x_s1; neg_y = 1'b0;
			end
		endcase
		px_nxt = neg_x ? cx_s1 - mag_x : cx_s1 + mag_x;
		py_nxt = neg_y ? cy_s1 - mag_y : cy_s1 + mag_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (step_valid) begin
			buf_vld_q <= 1'b1;
			idx_q     <= '0;
		end else if (out_load) begin
			if (buf_last) begin
				buf_vld_q <= 1'b0;
			end else begin
				idx_q <= idx_q + PIDX_BITS'(1);
			end
		end
	end

	// offsets wider than a point wrap like the point itself
	always_ff @(posedge clk) begin
		if (step_valid) begin
			cx_s1  <= PW'(step_cx);
			cy_s1  <= PW'(step_cy);
			x_s1   <= PW'(step_x);
			y_s1   <= PW'(step_y);
			ctl_s1 <= step_ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			px_s2   <= px_nxt;
			py_s2   <= py_nxt;
			last_s2 <= buf_last;
			done_s2 <= ctl_s1.done;
		end
	end

	assign out_valid    = out_vld_q;
	assign point_x      = $signed(px_s2);
	assign point_y      = $signed(py_s2);
	assign last_of_step = last_s2;
	assign circle_done  = done_s2;

endmodule

>>> rtl/circle_point_generator_core.sv
// ----------------------------------------------------------------------------
// circle_point_generator_core
// Midpoint-style circle outline rasterizer with eight-way symmetry.
// ----------------------------------------------------------------------------
// Channels: items (sink) carries start and advance commands, points (source)
// carries outline points, cfg (sink) writes arc_mode and is always ready.
// A start transfer loads center and radius and produces no point. Each
// advance transfer of an active circle produces eight points (full mode) or
// two points (lower arc), the final one flagged last_of_step; circle_done
// marks every point of the circle's final column.
// The first point of an advance passes the step buffer and then the output
// register. The points port moves one point per cycle while points is
// ready; a start or an empty advance produces no point. The next step is
// computed from running squares (adds only) and sits in a one-step buffer,
// so an item is taken as the previous step's last point moves on to the
// output register. If points stalls, the output register holds, the
// buffer fills and items drops ready until the buffered step's last point
// has moved on to the output register.
// Reset clears the circle state to idle and arc_mode to full.
// ----------------------------------------------------------------------------
module circle_point_generator_core #(
	parameter int COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	cpg_cfg_if.sink  cfg,
	cpg_in_if.sink   items,
	cpg_out_if.source points
);
	import cpg_pkg::*;

	localparam int XW  = RADIUS_BITS + 1;
	localparam int SQW = 2 * RADIUS_BITS + 2;

	arc_mode_t                    arc_mode_q;
	logic [XW-1:0]                offset_x_q;
	logic [RADIUS_BITS-1:0]       offset_y_q;
	logic signed [COORD_BITS-1:0] center_x_q;
	logic signed [COORD_BITS-1:0] center_y_q;
	logic [SQW-1:0]               radius_sq_q;
	logic [SQW-1:0]               x_sq_q;
	logic [SQW-1:0]               y_sq_q;
	logic                         active_q;

	logic                         in_xfer;
	logic                         is_start;
	logic                         in_range;
	logic                         emit;
	logic [XW-1:0]                nx;
	logic [SQW-1:0]               nx_sq;
	logic                         dec_y;
	logic [RADIUS_BITS-1:0]       ny;
	logic [SQW-1:0]               ny_sq;
	logic                         done;
	logic [SQW-1:0]               r_sq;
	logic                         step_ready;
	step_ctl_t                    step_ctl;

	assign cfg.ready = 1'b1;

	assign in_xfer  = items.valid && items.ready;
	assign is_start = (kind_t'(items.kind) == KIND_START);
	assign in_range = (offset_x_q <= {1'b0, offset_y_q});
	assign emit     = in_xfer && !is_start && active_q && in_range;

	// (x+1)^2 = x^2 + 2x + 1, (y-1)^2 = y^2 - 2y + 1
	assign nx    = offset_x_q + XW'(1);
	assign nx_sq = x_sq_q + SQW'({offset_x_q, 1'b0}) + SQW'(1);
	assign dec_y = (nx_sq + y_sq_q) > radius_sq_q;
	assign ny    = offset_y_q - RADIUS_BITS'(dec_y);
	assign ny_sq = dec_y ? y_sq_q - SQW'({offset_y_q, 1'b0}) + SQW'(1) : y_sq_q;
	// compare against y before the wrap of y-1 at zero
	assign done  = dec_y ? ({1'b0, offset_y_q} <= nx) : ({1'b0, offset_y_q} < nx);

	assign r_sq  = SQW'(items.radius) * SQW'(items.radius);

	assign step_ctl.mode = arc_mode_q;
	assign step_ctl.done = done;
	assign items.ready   = step_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_mode_q <= ARC_FULL;
		end else if (cfg.valid && cfg.ready) begin
			arc_mode_q <= arc_mode_t'(cfg.data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q  <= '0;
			offset_y_q  <= '0;
			center_x_q  <= '0;
			center_y_q  <= '0;
			radius_sq_q <= '0;
			x_sq_q      <= '0;
			y_sq_q      <= '0;
			active_q    <= 1'b0;
		end else if (in_xfer) begin
			if (is_start) begin
				center_x_q  <= items.center_x;
				center_y_q  <= items.center_y;
				offset_x_q  <= '0;
				offset_y_q  <= items.radius;
				radius_sq_q <= r_sq;
				x_sq_q      <= '0;
				y_sq_q      <= r_sq;
				active_q    <= 1'b1;
			end else if (active_q) begin
				if (in_range) begin
					offset_x_q <= nx;
					offset_y_q <= ny;
					x_sq_q     <= nx_sq;
					y_sq_q     <= ny_sq;
					if (done) begin
						active_q <= 1'b0;
					end
				end else begin
					active_q <= 1'b0;
				end
			end
		end
	end

	cpg_point_emitter #(
		.COORD_BITS (COORD_BITS),
		.RADIUS_BITS(RADIUS_BITS)
	) u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_valid  (emit),
		.step_ready  (step_ready),
		.step_cx     (center_x_q),
		.step_cy     (center_y_q),
		.step_x      (offset_x_q),
		.step_y      (offset_y_q),
		.step_ctl    (step_ctl),
		.out_valid   (points.valid),
		.out_ready   (points.ready),
		.point_x     (points.point_x),
		.point_y     (points.point_y),
		.last_of_step(points.last_of_step),
		.circle_done (points.circle_done)
	);

endmodule

>>> rtl/cpg_checker.sv
// ----------------------------------------------------------------------------
// cpg_checker
// Port-level checks of the circle point generator, bound to the top level.
// ----------------------------------------------------------------------------
module cpg_checker #(
	parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_kind,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [COORD_BITS:0] point_x,
	input logic signed [COORD_BITS:0] point_y,
	input logic                       last_of_step,
	input logic                       circle_done
);
	import cpg_pkg::*;

	// stalled point holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(last_of_step) && $stable(circle_done))
		else $error("stalled point changed");

	// points of one step follow back to back and agree on circle_done
	a_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_step |=> out_valid
			&& (circle_done == $past(circle_done)))
		else $error("step broken or circle_done differs within a step");

	// a fresh burst of points traces back to an earlier advance transfer
	a_burst_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready
			&& (kind_t'(in_kind) == KIND_ADVANCE), 2))
		else $error("points without a preceding advance transfer");

endmodule

bind circle_point_generator_core cpg_checker #(
	.COORD_BITS(COORD_BITS)
) u_cpg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (items.valid),
	.in_ready    (items.ready),
	.in_kind     (items.kind),
	.out_valid   (points.valid),
	.out_ready   (points.ready),
	.point_x     (points.point_x),
	.point_y     (points.point_y),
	.last_of_step(points.last_of_step),
	.circle_done (points.circle_done)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circle_point_generator_core. Start and advance
// commands go in over the items channel with random gaps, outline points are
// taken with random stalls. A built-in rasterizer predicts every point and
// each received point is checked field by field against the oldest one.
// arc_mode is switched between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import cpg_pkg::*;

	localparam int CB           = COORD_BITS_DEF;
	localparam int RB           = RADIUS_BITS_DEF;
	localparam int DRAIN_CYCLES = 12;
	localparam int QUIET_LIMIT  = 500;
	localparam int PHASE_ITEMS  = 58;

	localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic        [RB-1:0] RAD_MAX   = {RB{1'b1}};

	typedef struct packed {
		kind_t          kind;
		logic [CB-1:0]  center_x;
		logic [CB-1:0]  center_y;
		logic [RB-1:0]  radius;
	} circle_cmd_t;

	typedef struct packed {
		logic [CB:0] px;
		logic [CB:0] py;
		logic        last;
		logic        done;
	} outline_pt_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// driven inputs, known from time zero
	logic          in_valid  = 1'b0;
	kind_t         in_kind   = KIND_START;
	logic [CB-1:0] in_cx     = '0;
	logic [CB-1:0] in_cy     = '0;
	logic [RB-1:0] in_radius = '0;
	logic          cfg_valid = 1'b0;
	logic          cfg_data  = 1'b0;
	logic          pt_ready  = 1'b0;

	cpg_in_if  items_if ();
	cpg_out_if points_if ();
	cpg_cfg_if cfg_if ();

	assign items_if.valid    = in_valid;
	assign items_if.kind     = in_kind;
	assign items_if.center_x = in_cx;
	assign items_if.center_y = in_cy;
	assign items_if.radius   = in_radius;
	assign cfg_if.valid      = cfg_valid;
	assign cfg_if.data       = cfg_data;
	assign points_if.ready   = pt_ready;

	circle_point_generator_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.items  (items_if),
		.points (points_if)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	circle_cmd_t cmd_pending[$];
	arc_mode_t   mode_writes[$];
	outline_pt_t outline_expected[$];
	circle_cmd_t next_cmd;
	int          item_hold;
	int          pt_wait;
	int          pt_draw;
	int          quiet_cycles;
	int          mism_count;
	bit          src_idle;
	bit          snk_idle;

	// rasterizer state
	arc_mode_t            cur_mode;
	logic [RB:0]          ofs_x;
	logic [RB-1:0]        ofs_y;
	logic signed [CB-1:0] ctr_x;
	logic signed [CB-1:0] ctr_y;
	int                   rad_sq;
	bit                   drawing;

	task automatic rasterize_step(input circle_cmd_t c);
		int        x, y, nx, ny, cx, cy, px, py, npts;
		bit        fin;
		pt_slot_t  slot;
		outline_pt_t pt;
		if (c.kind == KIND_START) begin
			ctr_x   = c.center_x;
			ctr_y   = c.center_y;
			ofs_x   = '0;
			ofs_y   = c.radius;
			rad_sq  = int'(c.radius) * int'(c.radius);
			drawing = 1'b1;
			return;
		end
		if (!drawing)
			return;
		x = int'(ofs_x);
		y = int'(ofs_y);
		if (x > y) begin
			drawing = 1'b0;
			return;
		end
		nx = x + 1;
		ny = y;
		if (nx * nx + y * y > rad_sq)
			ny = y - 1;
		fin  = nx > ny;
		cx   = int'(ctr_x);
		cy   = int'(ctr_y);
		npts = (cur_mode == ARC_LOWER) ? 2 : 8;
		for (int k = 0; k < npts; k++) begin
			if (cur_mode == ARC_LOWER)
				slot = (k == 0) ? PT_XP_YN : PT_XN_YN;
			else
				slot = pt_slot_t'(k);
			case (slot)
				PT_XP_YP: begin px = cx + x; py = cy + y; end
				PT_XN_YP: begin px = cx - x; py = cy + y; end
				PT_XP_YN: begin px = cx + x; py = cy - y; end
				PT_XN_YN: begin px = cx - x; py = cy - y; end
				PT_YP_XP: begin px = cx + y; py = cy + x; end
				PT_YN_XN: begin px = cx - y; py = cy - x; end
				PT_YP_XN: begin px = cx + y; py = cy - x; end
				default:  begin px = cx - y; py = cy + x; end
			endcase
			pt.px   = px[CB:0];
			pt.py   = py[CB:0];
			pt.last = (k == npts - 1);
			pt.done = fin;
			outline_expected.push_back(pt);
		end
		ofs_x = nx[RB:0];
		ofs_y = ny[RB-1:0];
		if (fin)
			drawing = 1'b0;
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			item_hold <= 0;
		end else if (!in_valid || items_if.ready) begin
			if (item_hold != 0) begin
				in_valid  <= 1'b0;
				item_hold <= item_hold - 1;
			end else if (cmd_pending.size() != 0) begin
				next_cmd   = cmd_pending.pop_front();
				in_valid  <= 1'b1;
				in_kind   <= next_cmd.kind;
				in_cx     <= next_cmd.center_x;
				in_cy     <= next_cmd.center_y;
				in_radius <= next_cmd.radius;
				item_hold <= src_idle ? int'($urandom_range(0, 11)) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// arc_mode writer, one write in flight
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else if (cfg_valid && cfg_if.ready) begin
			cfg_valid <= 1'b0;
		end else if (!cfg_valid && mode_writes.size() != 0) begin
			cfg_data  <= mode_writes.pop_front();
			cfg_valid <= 1'b1;
		end
	end

	// point sink: ready drops for a random number of cycles after each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_ready <= 1'b1;
			pt_wait  <= 0;
		end else if (pt_wait != 0) begin
			pt_wait  <= pt_wait - 1;
			pt_ready <= (pt_wait == 1);
		end else if (points_if.valid && pt_ready) begin
			pt_draw   = snk_idle ? int'($urandom_range(0, 11)) : 0;
			pt_wait  <= pt_draw;
			pt_ready <= (pt_draw == 0);
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode     = ARC_FULL;
			ofs_x        = '0;
			ofs_y        = '0;
			ctr_x        = '0;
			ctr_y        = '0;
			rad_sq       = 0;
			drawing      = 1'b0;
			quiet_cycles <= 0;
		end else begin
			if (cfg_if.valid && cfg_if.ready)
				cur_mode = arc_mode_t'(cfg_if.data);
			if (items_if.valid && items_if.ready)
				rasterize_step('{kind: kind_t'(items_if.kind), center_x: items_if.center_x,
					center_y: items_if.center_y, radius: items_if.radius});
			if (points_if.valid && points_if.ready) begin
				if (outline_expected.size() == 0) begin
					$error("point_x: no point expected, got %0d (point_y %0d)",
						points_if.point_x, points_if.point_y);
					mism_count++;
				end else begin
					outline_pt_t want;
					want = outline_expected.pop_front();
					if (points_if.point_x !== want.px) begin
						$error("point_x: expected %0d, got %0d", $signed(want.px),
							points_if.point_x);
						mism_count++;
					end
					if (points_if.point_y !== want.py) begin
						$error("point_y: expected %0d, got %0d", $signed(want.py),
							points_if.point_y);
						mism_count++;
					end
					if (points_if.last_of_step !== want.last) begin
						$error("last_of_step: expected %0b, got %0b", want.last,
							points_if.last_of_step);
						mism_count++;
					end
					if (points_if.circle_done !== want.done) begin
						$error("circle_done: expected %0b, got %0b", want.done,
							points_if.circle_done);
						mism_count++;
					end
				end
			end
			if ((items_if.valid && items_if.ready) || (points_if.valid && points_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("simulation failed");
		$finish;
	end

	function automatic logic [CB-1:0] rand_coord();
		int tmp;
		tmp = $urandom();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
		return tmp[CB-1:0];
	endfunction

	function automatic logic [RB-1:0] rand_radius();
		int tmp;
		tmp = $urandom();
		return tmp[RB-1:0];
	endfunction

	task automatic queue_cmd(input kind_t k, input logic [CB-1:0] x, input logic [CB-1:0] y,
			input logic [RB-1:0] r);
		cmd_pending.push_back('{kind: k, center_x: x, center_y: y, radius: r});
	endtask

	task automatic queue_advances(input int n);
		repeat (n) queue_cmd(KIND_ADVANCE, rand_coord(), rand_coord(), rand_radius());
	endtask

	// all commands taken, all points out, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		while (cmd_pending.size() != 0 || in_valid || outline_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_arc_mode(input arc_mode_t m);
		wait_idle();
		mode_writes.push_back(m);
		@(negedge clk);
		while (mode_writes.size() != 0 || cfg_valid)
			@(negedge clk);
	endtask

	initial begin
		int        budget, steps, sel, rad;
		arc_mode_t ph_mode;
		src_idle   = 1'b1;
		snk_idle   = 1'b1;
		mism_count = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// full circle: idle advance, zero radius, extreme centers and radius,
		// abandoned circle, a small circle run past its end
		set_arc_mode(ARC_FULL);
		queue_advances(1);
		queue_cmd(KIND_START, COORD_MAX, COORD_MIN, '0);
		queue_advances(2);
		queue_cmd(KIND_START, COORD_MIN, COORD_MAX, RAD_MAX);
		queue_advances(3);
		queue_cmd(KIND_START, '0, '0, RB'(3));
		queue_advances(4);

		// lower arc
		set_arc_mode(ARC_LOWER);
		queue_cmd(KIND_START, COORD_MIN, COORD_MIN, RB'(5));
		queue_advances(6);
		queue_cmd(KIND_START, COORD_MAX, COORD_MAX, '0);
		queue_advances(2);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 4)
				ph_mode = (ph % 2) ? ARC_FULL : ARC_LOWER;
			else
				ph_mode = arc_mode_t'($urandom_range(0, 1));
			set_arc_mode(ph_mode);
			src_idle = ($urandom_range(0, 3) != 0);
			snk_idle = ($urandom_range(0, 3) != 0);
			budget = 0;
			while (budget < PHASE_ITEMS) begin
				sel = $urandom_range(0, 99);
				if (sel < 70)
					rad = $urandom_range(0, 24);
				else if (sel < 90)
					rad = $urandom_range(25, 120);
				else if (sel < 96)
					rad = $urandom_range(0, 1023);
				else
					rad = 1023;
				if ($urandom_range(0, 19) == 0) begin
					// stray advance, possibly while idle
					queue_advances(1);
					budget++;
				end
				queue_cmd(KIND_START, rand_coord(), rand_coord(), rad[RB-1:0]);
				steps = rad * 707 / 1000 + 2;
				if (steps > 40)
					steps = $urandom_range(3, 40);
				else if ($urandom_range(0, 7) == 0)
					steps = $urandom_range(0, steps);
				else
					steps += $urandom_range(0, 2);
				queue_advances(steps);
				budget += steps + 1;
			end
		end

		wait_idle();
		if (mism_count == 0 && outline_expected.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/cpg_pkg.sv
rtl/cpg_if.sv
rtl/cpg_point_emitter.sv
rtl/circle_point_generator_core.sv
rtl/cpg_checker.sv
dv/testbench.sv
